FILE: sv/ucd_pkg.sv
`timescale 1ns / 1ps

package ucd_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  localparam int NODE_W = 7;
  localparam int NODE_IDX_W = $clog2(MAX_NODES);
  localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
  localparam int HELD_W = EDGE_IDX_W + 1;
  localparam int ENTRY_W = HELD_W + 1;
  localparam int EDGES_OUT_W = 9;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic en;
    logic [EDGE_IDX_W-1:0] addr;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } edge_wr_t;

  typedef struct packed {
    logic en;
    logic [NODE_IDX_W-1:0] addr;
    logic [NODE_W-1:0] node;
  } stack_wr_t;

endpackage

FILE: sv/ucd_edge_store.sv
`timescale 1ns / 1ps

module ucd_edge_store (
  input  logic                                clk,
  input  ucd_pkg::edge_wr_t                   wr,
  input  logic [ucd_pkg::EDGE_IDX_W-1:0]      rd_addr,
  output logic [ucd_pkg::NODE_W-1:0]          rd_a,
  output logic [ucd_pkg::NODE_W-1:0]          rd_b
);

  logic [2*ucd_pkg::NODE_W-1:0] mem [ucd_pkg::MAX_EDGES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.a, wr.b};
    end
    {rd_a, rd_b} <= mem[rd_addr];
  end

endmodule

FILE: sv/ucd_walk_stack.sv
`timescale 1ns / 1ps

module ucd_walk_stack (
  input  logic                                clk,
  input  ucd_pkg::stack_wr_t                  wr,
  input  logic [ucd_pkg::NODE_IDX_W-1:0]      rd_addr,
  output logic [ucd_pkg::NODE_W-1:0]          rd_data
);

  logic [ucd_pkg::NODE_W-1:0] mem [ucd_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.node;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/undirected_cycle_detect.sv
`timescale 1ns / 1ps
// Add-edge and clear words leave busy low, so a new word can follow at once.
// A run visits each node index from 1 to the node limit and then closes, with extra work per
// component and for every node popped from the walk stack, since each popped node scans the
// whole edge list through the single edge store read port.
// Each result word is flagged by result_strobe for exactly one cycle; the receiver cannot stall.
// Synchronous reset empties the edge store, clears the overflow flag and sets node_count to 64.

module undirected_cycle_detect (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ucd_pkg::FUNC_W-1:0]         func,
  input  logic [ucd_pkg::NODE_W-1:0]         node_a,
  input  logic [ucd_pkg::NODE_W-1:0]         node_b,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ucd_pkg::NODE_W-1:0]         cfg_data,
  output logic                               result_strobe,
  output logic [ucd_pkg::NODE_W-1:0]         component_root,
  output logic [ucd_pkg::NODE_W-1:0]         component_nodes,
  output logic [ucd_pkg::EDGES_OUT_W-1:0]    component_edges,
  output logic                               has_cycle,
  output logic                               edge_overflow,
  output logic                               last_result
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_POP  = 5'b00100,
    S_WAIT = 5'b01000,
    S_EDGE = 5'b10000
  } state_t;

  state_t state;

  logic [ucd_pkg::HELD_W-1:0]       held;
  logic                             ovf;
  logic [ucd_pkg::NODE_W-1:0]       node_count;
  logic [ucd_pkg::NODE_W-1:0]       lim;
  logic [ucd_pkg::MAX_NODES-1:0]    visited;
  logic [ucd_pkg::NODE_W-1:0]       root;
  logic [ucd_pkg::NODE_W-1:0]       sp;
  logic [ucd_pkg::NODE_W-1:0]       u;
  logic [ucd_pkg::EDGE_IDX_W-1:0]   e;
  logic [ucd_pkg::NODE_W-1:0]       node_tally;
  logic [ucd_pkg::ENTRY_W-1:0]      entry_tally;
  logic                             pending;
  logic [ucd_pkg::NODE_W-1:0]       pend_root;
  logic [ucd_pkg::NODE_W-1:0]       pend_nodes;
  logic [ucd_pkg::EDGES_OUT_W-1:0]  pend_edges;

  logic                             accept;
  ucd_pkg::edge_wr_t                edge_wr;
  logic [ucd_pkg::EDGE_IDX_W-1:0]   edge_rd_addr;
  logic [ucd_pkg::NODE_W-1:0]       ea;
  logic [ucd_pkg::NODE_W-1:0]       eb;
  ucd_pkg::stack_wr_t               stack_wr;
  logic [ucd_pkg::NODE_W-1:0]       sp_m1;
  logic [ucd_pkg::NODE_W-1:0]       stack_rd;
  logic [ucd_pkg::NODE_W-1:0]       ea_m1;
  logic [ucd_pkg::NODE_W-1:0]       eb_m1;
  logic [ucd_pkg::NODE_W-1:0]       root_m1;
  logic                             in_range;
  logic                             hit_a;
  logic                             hit_b;
  logic                             push_b_node;
  logic                             push_a_node;
  logic                             push_any;
  logic [ucd_pkg::NODE_W-1:0]       push_node;
  logic [ucd_pkg::NODE_W-1:0]       push_m1;
  logic                             pend_cycle;
  logic [ucd_pkg::HELD_W-1:0]       e_inc;
  logic                             emit;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  assign ea_m1 = ea - ucd_pkg::NODE_W'(1);
  assign eb_m1 = eb - ucd_pkg::NODE_W'(1);
  assign root_m1 = root - ucd_pkg::NODE_W'(1);
  assign sp_m1 = sp - ucd_pkg::NODE_W'(1);
  assign e_inc = {1'b0, e} + ucd_pkg::HELD_W'(1);

  assign in_range = (ea != '0) && (eb != '0) && (ea <= lim) && (eb <= lim);
  assign hit_a = in_range && (ea == u);
  assign hit_b = in_range && (eb == u);
  assign push_b_node = hit_a && !visited[eb_m1[ucd_pkg::NODE_IDX_W-1:0]];
  assign push_a_node = hit_b && !visited[ea_m1[ucd_pkg::NODE_IDX_W-1:0]] && !push_b_node;
  assign push_any = (state == S_EDGE) && (push_b_node || push_a_node);
  assign push_node = push_b_node ? eb : ea;
  assign push_m1 = push_node - ucd_pkg::NODE_W'(1);

  assign pend_cycle = ({1'b0, pend_edges} + ucd_pkg::ENTRY_W'(1))
                      != ucd_pkg::ENTRY_W'(pend_nodes);

  assign emit = (state == S_SCAN) && pending
                && ((root > lim) || !visited[root_m1[ucd_pkg::NODE_IDX_W-1:0]]);

  always_comb begin
    edge_wr.en = accept && (func == ucd_pkg::FUNC_ADD)
                 && (held < ucd_pkg::HELD_W'(ucd_pkg::MAX_EDGES));
    edge_wr.addr = held[ucd_pkg::EDGE_IDX_W-1:0];
    edge_wr.a = node_a;
    edge_wr.b = node_b;
    edge_rd_addr = (state == S_WAIT) ? '0 : e_inc[ucd_pkg::EDGE_IDX_W-1:0];
  end

  always_comb begin
    if (state == S_SCAN) begin
      stack_wr.en = (root <= lim) && !visited[root_m1[ucd_pkg::NODE_IDX_W-1:0]];
      stack_wr.addr = '0;
      stack_wr.node = root;
    end else begin
      stack_wr.en = push_any;
      stack_wr.addr = sp[ucd_pkg::NODE_IDX_W-1:0];
      stack_wr.node = push_node;
    end
  end

  ucd_edge_store u_edge_store (
    .clk     (clk),
    .wr      (edge_wr),
    .rd_addr (edge_rd_addr),
    .rd_a    (ea),
    .rd_b    (eb)
  );

  ucd_walk_stack u_walk_stack (
    .clk     (clk),
    .wr      (stack_wr),
    .rd_addr (sp_m1[ucd_pkg::NODE_IDX_W-1:0]),
    .rd_data (stack_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held <= '0;
      ovf <= 1'b0;
      node_count <= ucd_pkg::NODE_W'(ucd_pkg::MAX_NODES);
      visited <= '0;
      sp <= '0;
      pending <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              ucd_pkg::FUNC_ADD: begin
                if (held < ucd_pkg::HELD_W'(ucd_pkg::MAX_EDGES)) begin
                  held <= held + ucd_pkg::HELD_W'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              ucd_pkg::FUNC_CLEAR: begin
                held <= '0;
                ovf <= 1'b0;
              end
              ucd_pkg::FUNC_RUN: begin
                visited <= '0;
                root <= ucd_pkg::NODE_W'(1);
                pending <= 1'b0;
                lim <= (node_count > ucd_pkg::NODE_W'(ucd_pkg::MAX_NODES))
                       ? ucd_pkg::NODE_W'(ucd_pkg::MAX_NODES) : node_count;
                state <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (root > lim) begin
            if (pending) begin
              component_root <= pend_root;
              component_nodes <= pend_nodes;
              component_edges <= pend_edges;
              has_cycle <= pend_cycle;
              edge_overflow <= ovf;
              last_result <= 1'b1;
            end
            pending <= 1'b0;
            state <= S_IDLE;
          end else if (visited[root_m1[ucd_pkg::NODE_IDX_W-1:0]]) begin
            root <= root + ucd_pkg::NODE_W'(1);
          end else begin
            if (pending) begin
              component_root <= pend_root;
              component_nodes <= pend_nodes;
              component_edges <= pend_edges;
              has_cycle <= pend_cycle;
              edge_overflow <= ovf;
              last_result <= 1'b0;
            end
            pending <= 1'b0;
            visited[root_m1[ucd_pkg::NODE_IDX_W-1:0]] <= 1'b1;
            sp <= ucd_pkg::NODE_W'(1);
            node_tally <= '0;
            entry_tally <= '0;
            state <= S_POP;
          end
        end
        S_POP: begin
          if (sp == '0) begin
            pend_root <= root;
            pend_nodes <= node_tally;
            pend_edges <= entry_tally[ucd_pkg::ENTRY_W-1:1];
            pending <= 1'b1;
            root <= root + ucd_pkg::NODE_W'(1);
            state <= S_SCAN;
          end else begin
            sp <= sp_m1;
            node_tally <= node_tally + ucd_pkg::NODE_W'(1);
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          u <= stack_rd;
          e <= '0;
          state <= (held == '0) ? S_POP : S_EDGE;
        end
        S_EDGE: begin
          entry_tally <= entry_tally + ucd_pkg::ENTRY_W'(hit_a) + ucd_pkg::ENTRY_W'(hit_b);
          if (push_any) begin
            visited[push_m1[ucd_pkg::NODE_IDX_W-1:0]] <= 1'b1;
            sp <= sp + ucd_pkg::NODE_W'(1);
          end
          if (e_inc < held) begin
            e <= e_inc[ucd_pkg::EDGE_IDX_W-1:0];
          end else begin
            state <= S_POP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cycle_flag: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (has_cycle == (({1'b0, component_edges} + ucd_pkg::ENTRY_W'(1))
                                     != ucd_pkg::ENTRY_W'(component_nodes))))
    else $error("cycle flag disagrees with node and edge counts");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_result) |-> !busy)
    else $error("final result word shown while the run is still going");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_result) |-> busy)
    else $error("non-final result word shown after the run ended");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= ucd_pkg::NODE_W'(ucd_pkg::MAX_NODES))
    else $error("walk stack pointer beyond stack depth");

endmodule

FILE: verif/undirected_cycle_detect_tb.sv
`timescale 1ns / 1ps

module undirected_cycle_detect_tb;

  localparam logic [ucd_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [ucd_pkg::NODE_W-1:0]      root;
    logic [ucd_pkg::NODE_W-1:0]      nodes;
    logic [ucd_pkg::EDGES_OUT_W-1:0] edges;
    logic                            cyc;
    logic                            ovf;
    logic                            last;
  } component_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic [ucd_pkg::FUNC_W-1:0]      func = ucd_pkg::FUNC_ADD;
  logic [ucd_pkg::NODE_W-1:0]      node_a = '0;
  logic [ucd_pkg::NODE_W-1:0]      node_b = '0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ucd_pkg::NODE_W-1:0]      cfg_data = '0;
  logic                            result_strobe;
  logic [ucd_pkg::NODE_W-1:0]      component_root;
  logic [ucd_pkg::NODE_W-1:0]      component_nodes;
  logic [ucd_pkg::EDGES_OUT_W-1:0] component_edges;
  logic                            has_cycle;
  logic                            edge_overflow;
  logic                            last_result;

  // Software copy of the block state, updated as each word is accepted.
  logic [ucd_pkg::NODE_W-1:0] stored_a [ucd_pkg::MAX_EDGES];
  logic [ucd_pkg::NODE_W-1:0] stored_b [ucd_pkg::MAX_EDGES];
  int unsigned                edges_kept = 0;
  bit                         dropped_edge = 0;
  logic [ucd_pkg::NODE_W-1:0] node_limit = 7'd64;

  component_t  components_due[$];
  int unsigned mismatches = 0;
  bit          sender_steady = 0;

  always #2 clk = ~clk;

  undirected_cycle_detect dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .node_a          (node_a),
    .node_b          (node_b),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .result_strobe   (result_strobe),
    .component_root  (component_root),
    .component_nodes (component_nodes),
    .component_edges (component_edges),
    .has_cycle       (has_cycle),
    .edge_overflow   (edge_overflow),
    .last_result     (last_result)
  );

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Depth-first walk over every unvisited node, one component per root.
  task automatic predict_components();
    int unsigned span, sp, u, a, b, node_total, entry_total, pair_total;
    bit          seen [ucd_pkg::MAX_NODES + 1];
    int unsigned pending [ucd_pkg::MAX_NODES + 1];
    component_t  comp;
    component_t  found[$];
    span = (32'(node_limit) > ucd_pkg::MAX_NODES) ? ucd_pkg::MAX_NODES : 32'(node_limit);
    for (int i = 0; i <= ucd_pkg::MAX_NODES; i++) seen[i] = 1'b0;
    for (int root = 1; root <= span; root++) begin
      if (seen[root]) continue;
      seen[root] = 1'b1;
      pending[0] = root;
      sp = 1;
      node_total = 0;
      entry_total = 0;
      while (sp > 0) begin
        sp--;
        u = pending[sp];
        node_total++;
        for (int e = 0; e < edges_kept && e < ucd_pkg::MAX_EDGES; e++) begin
          a = 32'(stored_a[e]);
          b = 32'(stored_b[e]);
          if (a == 0 || b == 0 || a > span || b > span) continue;
          if (a == u) begin
            entry_total++;
            if (!seen[b] && sp <= ucd_pkg::MAX_NODES) begin
              seen[b] = 1'b1;
              pending[sp] = b;
              sp++;
            end
          end
          if (b == u) begin
            entry_total++;
            if (!seen[a] && sp <= ucd_pkg::MAX_NODES) begin
              seen[a] = 1'b1;
              pending[sp] = a;
              sp++;
            end
          end
        end
      end
      pair_total = entry_total / 2;
      comp.root = ucd_pkg::NODE_W'(root);
      comp.nodes = ucd_pkg::NODE_W'(node_total);
      comp.edges = ucd_pkg::EDGES_OUT_W'(pair_total);
      comp.cyc = (pair_total + 1 != node_total);
      comp.ovf = dropped_edge;
      comp.last = 1'b0;
      found = {found, comp};
    end
    if (found.size() > 0) begin
      comp = found.pop_back();
      comp.last = 1'b1;
      found = {found, comp};
    end
    foreach (found[i]) components_due = {components_due, found[i]};
  endtask

  task automatic apply_word(input logic [ucd_pkg::FUNC_W-1:0] f,
                            input logic [ucd_pkg::NODE_W-1:0] a,
                            input logic [ucd_pkg::NODE_W-1:0] b);
    case (f)
      ucd_pkg::FUNC_ADD: begin
        if (edges_kept < ucd_pkg::MAX_EDGES) begin
          stored_a[edges_kept] = a;
          stored_b[edges_kept] = b;
          edges_kept++;
        end else begin
          dropped_edge = 1;
        end
      end
      ucd_pkg::FUNC_CLEAR: begin
        edges_kept = 0;
        dropped_edge = 0;
      end
      ucd_pkg::FUNC_RUN: predict_components();
      default: ;
    endcase
  endtask

  // Leaves start high so that a following word can go out back to back.
  task automatic send_word(input logic [ucd_pkg::FUNC_W-1:0] f,
                           input logic [ucd_pkg::NODE_W-1:0] a,
                           input logic [ucd_pkg::NODE_W-1:0] b);
    bit taken;
    if (!sender_steady && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    node_a <= a;
    node_b <= b;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      if (!busy) begin
        taken = 1;
        apply_word(f, a, b);
      end
      @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    do @(negedge clk); while (components_due.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [ucd_pkg::NODE_W-1:0] value);
    bit taken;
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      if (cfg_ready) begin
        taken = 1;
        node_limit = value;
      end
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ucd_pkg::NODE_W-1:0] pick_endpoint(input int unsigned span);
    if ($urandom_range(0, 19) == 0) return ucd_pkg::NODE_W'($urandom_range(0, 127));
    return ucd_pkg::NODE_W'($urandom_range(1, (span == 0) ? 1 : span));
  endfunction

  function automatic logic [ucd_pkg::NODE_W-1:0] any_node();
    return ucd_pkg::NODE_W'($urandom_range(0, 127));
  endfunction

  task automatic test_directed_edges();
    send_word(ucd_pkg::FUNC_ADD, 1, 2);
    send_word(ucd_pkg::FUNC_ADD, 2, 3);
    send_word(ucd_pkg::FUNC_ADD, 3, 1);
    send_word(ucd_pkg::FUNC_ADD, 4, 4);
    send_word(ucd_pkg::FUNC_ADD, 5, 6);
    send_word(ucd_pkg::FUNC_ADD, 6, 5);
    send_word(ucd_pkg::FUNC_ADD, 10, 11);
    send_word(ucd_pkg::FUNC_ADD, 11, 12);
    send_word(ucd_pkg::FUNC_ADD, 0, 7);
    send_word(ucd_pkg::FUNC_ADD, 64, 63);
    send_word(ucd_pkg::FUNC_ADD, 127, 1);
    send_word(FUNC_UNUSED, 127, 127);
    send_word(ucd_pkg::FUNC_RUN, 127, 127);
    wait_quiet();
    send_word(ucd_pkg::FUNC_CLEAR, 127, 127);
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
  endtask

  task automatic test_node_count_extremes();
    write_node_count(0);
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
    write_node_count(127);
    send_word(ucd_pkg::FUNC_ADD, 65, 1);
    send_word(ucd_pkg::FUNC_ADD, 64, 1);
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
    write_node_count(1);
    send_word(ucd_pkg::FUNC_ADD, 1, 1);
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
    write_node_count(2);
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
  endtask

  task automatic test_random_graphs(input int unsigned word_goal);
    int unsigned sent, edges_now, span, pick;
    sent = 0;
    while (sent < word_goal) begin
      sender_steady = (sent > word_goal / 3) && (sent < 2 * word_goal / 3);
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) write_node_count(0);
        else if (pick == 1) write_node_count(ucd_pkg::NODE_W'(ucd_pkg::MAX_NODES));
        else if (pick == 2)
          write_node_count(ucd_pkg::NODE_W'($urandom_range(ucd_pkg::MAX_NODES + 1, 127)));
        else write_node_count(ucd_pkg::NODE_W'($urandom_range(1, 16)));
      end
      span = (32'(node_limit) > ucd_pkg::MAX_NODES) ? ucd_pkg::MAX_NODES : 32'(node_limit);
      if ($urandom_range(0, 3) != 0) begin
        send_word(ucd_pkg::FUNC_CLEAR, any_node(), any_node());
        sent++;
      end
      edges_now = $urandom_range(0, 12);
      repeat (edges_now) begin
        if ($urandom_range(0, 19) == 0) begin
          send_word(FUNC_UNUSED, any_node(), any_node());
        end else begin
          send_word(ucd_pkg::FUNC_ADD, pick_endpoint(span), pick_endpoint(span));
          sent++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        send_word(ucd_pkg::FUNC_RUN, any_node(), any_node());
        sent++;
      end
    end
    sender_steady = 0;
  endtask

  task automatic test_store_full();
    write_node_count(8);
    send_word(ucd_pkg::FUNC_CLEAR, 0, 0);
    sender_steady = 1;
    repeat (ucd_pkg::MAX_EDGES + 3)
      send_word(ucd_pkg::FUNC_ADD, pick_endpoint(8), pick_endpoint(8));
    sender_steady = 0;
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
    write_node_count(ucd_pkg::NODE_W'(ucd_pkg::MAX_NODES));
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
    send_word(ucd_pkg::FUNC_CLEAR, 0, 0);
    send_word(ucd_pkg::FUNC_ADD, 1, 2);
    send_word(ucd_pkg::FUNC_RUN, 0, 0);
  endtask

  always @(negedge clk) begin
    component_t want;
    if (!rst && result_strobe) begin
      if (components_due.size() == 0) begin
        report_mismatch("unexpected word, root", 32'(component_root), 0);
      end else begin
        want = components_due.pop_front();
        if (component_root !== want.root)
          report_mismatch("component_root", 32'(component_root), 32'(want.root));
        if (component_nodes !== want.nodes)
          report_mismatch("component_nodes", 32'(component_nodes), 32'(want.nodes));
        if (component_edges !== want.edges)
          report_mismatch("component_edges", 32'(component_edges), 32'(want.edges));
        if (has_cycle !== want.cyc)
          report_mismatch("has_cycle", 32'(has_cycle), 32'(want.cyc));
        if (edge_overflow !== want.ovf)
          report_mismatch("edge_overflow", 32'(edge_overflow), 32'(want.ovf));
        if (last_result !== want.last)
          report_mismatch("last_result", 32'(last_result), 32'(want.last));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_node_count_extremes();
    test_random_graphs(20);
    test_store_full();
    wait_quiet();
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && components_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
